// ----- sv/wsa_pkg.sv -----
`default_nettype none

package wsa_pkg;

   localparam int NUM_LANES   = 3;
   localparam int DIST_W      = 16;
   localparam int ANGLE_W     = 9;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam int STEP_W      = $clog2(DIST_W);
   localparam int AVG_STEPS   = DIST_W;
   localparam int MAP_STEPS   = ANGLE_W;
   localparam int MAX_SAMPLES_DEF = 1024;

   localparam logic [DIST_W-1:0]  MIN_DIST_RST  = 16'd50;
   localparam logic [DIST_W-1:0]  MAX_DIST_RST  = 16'd500;
   localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST = 9'd180;
   localparam logic [ANGLE_W-1:0] DEADBAND_RST  = 9'd2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MIN_DIST  = 2'd0,
      CSR_MAX_DIST  = 2'd1,
      CSR_MAX_ANGLE = 2'd2,
      CSR_DEADBAND  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DIST_W-1:0]  min_distance;
      logic [DIST_W-1:0]  max_distance;
      logic [ANGLE_W-1:0] max_angle;
      logic [ANGLE_W-1:0] deadband;
   } cfg_type;

   typedef struct packed {
      logic accumulate;
      logic close;
      logic step;
      logic use_range;
      logic map;
      logic commit;
   } lane_ctl_type;

   typedef struct packed {
      logic [DIST_W-1:0]  avg;
      logic [ANGLE_W-1:0] angle;
      logic               move;
   } lane_res_type;

endpackage

`default_nettype wire

// ----- sv/window_average_to_servo_angle.sv -----
// Channel  Ports        Direction  Contents
// req      req_t*       in         three distance samples, close flag in tuser
// rsp      rsp_t*       out        three averages and angles, move flags in tuser
// csr      csr_*        in         register writes, no read-back
//
// An item without the close flag leaves the block ready for the next item.
// A closing item makes the block busy: 16 steps of each lane's radix-2 divider
// for the average, a multiply, 9 divider steps for the angle, and then a merge of
// the lanes into the output register, which offers the result, once it is free.
// Reset is synchronous and active high; it restores state but not the data registers.
// A stalled result is held in the output register while new items are taken.

`default_nettype none

module window_average_to_servo_angle #(
   parameter int MAX_SAMPLES = wsa_pkg::MAX_SAMPLES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [47:0]                     req_tdata,  // dist_a, dist_b, dist_c
   input  wire logic [0:0]                      req_tuser,  // close_window
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [79:0]                          rsp_tdata,  // avg_a, avg_b, avg_c,
                                                            // angle_a, angle_b, angle_c
   output logic [2:0]                           rsp_tuser,  // move_a, move_b, move_c
   input  wire logic                            csr_we,
   input  wire logic [wsa_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [wsa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import wsa_pkg::*;

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = $clog2(longint'(MAX_SAMPLES) * ((longint'(1) << DIST_W) - 1) + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG,
      ST_MAP,
      ST_ANG,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [CNT_W-1:0]   divisor_ff;
   logic               rsp_tvalid_ff;
   logic [79:0]        rsp_tdata_ff;
   logic [79:0]        rsp_tdata_in;
   logic [2:0]         rsp_tuser_ff;
   logic [2:0]         rsp_tuser_in;
   cfg_type            cfg_ff;

   logic               accept;
   logic               not_full;
   logic               out_free;
   lane_ctl_type       ctl;
   lane_res_type       res [NUM_LANES];

   assign accept   = req_tvalid && req_tready;
   assign not_full = (count_ff < CNT_W'(MAX_SAMPLES));
   assign count_in = not_full ? count_ff + 1'b1 : count_ff;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      ctl            = '0;
      ctl.accumulate = accept && not_full;
      ctl.close      = accept && req_tuser[0];
      ctl.step       = (state_ff == ST_AVG) || (state_ff == ST_ANG);
      ctl.use_range  = (state_ff == ST_ANG);
      ctl.map        = (state_ff == ST_MAP);
      ctl.commit     = (state_ff == ST_DONE) && out_free;
   end

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      wsa_lane #(
         .CNT_W (CNT_W),
         .SUM_W (SUM_W)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .cfg    (cfg_ff),
         .ctl    (ctl),
         .sample (req_tdata[i*DIST_W +: DIST_W]),
         .count  (divisor_ff),
         .res    (res[i])
      );
   end

   always_comb begin
      rsp_tdata_in = '0;
      rsp_tuser_in = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         rsp_tdata_in[i*DIST_W +: DIST_W] = res[i].avg;
         rsp_tdata_in[NUM_LANES*DIST_W + i*ANGLE_W +: ANGLE_W] = res[i].angle;
         rsp_tuser_in[i] = res[i].move;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tready && (state_ff != ST_DONE)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_tuser[0]) begin
                     divisor_ff <= count_in;
                     count_ff   <= '0;
                     step_ff    <= '0;
                     state_ff   <= ST_AVG;
                  end else begin
                     count_ff <= count_in;
                  end
               end
            end
            ST_AVG: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(AVG_STEPS - 1)) begin
                  state_ff <= ST_MAP;
               end
            end
            ST_MAP: begin
               step_ff  <= '0;
               state_ff <= ST_ANG;
            end
            ST_ANG: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(MAP_STEPS - 1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= rsp_tdata_in;
                  rsp_tuser_ff  <= rsp_tuser_in;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_distance <= MIN_DIST_RST;
         cfg_ff.max_distance <= MAX_DIST_RST;
         cfg_ff.max_angle    <= MAX_ANGLE_RST;
         cfg_ff.deadband     <= DEADBAND_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_MIN_DIST:  cfg_ff.min_distance <= csr_wdata[DIST_W-1:0];
            CSR_MAX_DIST:  cfg_ff.max_distance <= csr_wdata[DIST_W-1:0];
            CSR_MAX_ANGLE: cfg_ff.max_angle    <= csr_wdata[ANGLE_W-1:0];
            CSR_DEADBAND:  cfg_ff.deadband     <= csr_wdata[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

// ----- sv/wsa_lane.sv -----
`default_nettype none

module wsa_lane #(
   parameter int CNT_W = 11,
   parameter int SUM_W = 26
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire wsa_pkg::cfg_type            cfg,
   input  wire wsa_pkg::lane_ctl_type       ctl,
   input  wire logic [wsa_pkg::DIST_W-1:0]  sample,
   input  wire logic [CNT_W-1:0]            count,
   output wsa_pkg::lane_res_type            res
);
   import wsa_pkg::*;

   localparam int DIV_W  = (CNT_W > DIST_W) ? CNT_W : DIST_W;
   localparam int PROD_W = DIST_W + ANGLE_W;

   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W-1:0]   sum_in;
   logic [DIV_W-1:0]   rem_ff;
   logic [DIV_W-1:0]   rem_in;
   logic [DIST_W-1:0]  num_ff;
   logic [DIST_W-1:0]  quo_ff;
   logic [DIST_W-1:0]  avg_ff;
   logic [ANGLE_W:0]   last_ff;

   logic [DIST_W-1:0]  range;
   logic               degenerate;
   logic [DIV_W-1:0]   divisor;
   logic [DIV_W:0]     trial;
   logic [DIV_W:0]     trial_sub;
   logic               ge;
   logic [DIST_W-1:0]  clamped;
   logic [DIST_W-1:0]  offset;
   logic [PROD_W-1:0]  prod;
   logic [ANGLE_W-1:0] angle;
   logic signed [ANGLE_W+1:0] delta;
   logic [ANGLE_W+1:0] mag;
   logic               move;

   assign sum_in     = sum_ff + (ctl.accumulate ? SUM_W'(sample) : '0);
   assign range      = cfg.max_distance - cfg.min_distance;
   assign degenerate = (cfg.max_distance <= cfg.min_distance);
   assign divisor    = ctl.use_range ? DIV_W'(range) : DIV_W'(count);
   assign trial      = {rem_ff, num_ff[DIST_W-1]};
   assign trial_sub  = trial - {1'b0, divisor};
   assign ge         = (trial >= {1'b0, divisor});
   assign rem_in     = ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];

   always_comb begin
      if (quo_ff < cfg.min_distance) begin
         clamped = cfg.min_distance;
      end else if (quo_ff > cfg.max_distance) begin
         clamped = cfg.max_distance;
      end else begin
         clamped = quo_ff;
      end
   end

   assign offset = clamped - cfg.min_distance;
   assign prod   = PROD_W'(offset) * PROD_W'(cfg.max_angle);

   assign angle = degenerate ? '0 : quo_ff[ANGLE_W-1:0];
   assign delta = $signed({2'b00, angle}) - $signed({last_ff[ANGLE_W], last_ff});
   assign mag   = delta[ANGLE_W+1] ? ($unsigned(-delta)) : $unsigned(delta);
   assign move  = (mag >= {2'b00, cfg.deadband});

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         last_ff <= '1;
      end else begin
         if (ctl.close) begin
            sum_ff <= '0;
         end else if (ctl.accumulate) begin
            sum_ff <= sum_in;
         end
         if (ctl.commit && move) begin
            last_ff <= {1'b0, angle};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.close) begin
         rem_ff <= DIV_W'(sum_in[SUM_W-1:DIST_W]);
         num_ff <= sum_in[DIST_W-1:0];
      end else if (ctl.map) begin
         avg_ff <= quo_ff;
         rem_ff <= DIV_W'(prod[PROD_W-1:ANGLE_W]);
         num_ff <= {prod[ANGLE_W-1:0], (DIST_W-ANGLE_W)'(0)};
      end else if (ctl.step) begin
         rem_ff <= rem_in;
         num_ff <= {num_ff[DIST_W-2:0], 1'b0};
         quo_ff <= {quo_ff[DIST_W-2:0], ge};
      end
   end

   assign res.avg   = avg_ff;
   assign res.angle = angle;
   assign res.move  = move;

endmodule

`default_nettype wire

// ----- sv/wsa_checker.sv -----
`default_nettype none

module wsa_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [0:0]                      req_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [79:0]                     rsp_tdata,
   input wire logic [2:0]                      rsp_tuser
);

   // A result that is not taken stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // An item that leaves the window open never makes the block busy.
   a_open_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser[0] |=> req_tready)
      else $error("not ready after an item that keeps the window open");

   // Closing the window starts the computation, so no item is taken next.
   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=> !req_tready)
      else $error("ready right after a closing item");

endmodule

bind window_average_to_servo_angle wsa_checker u_wsa_checker (.*);

`default_nettype wire
